FILE: rtl/mma_pkg.sv
`timescale 1ns / 1ps

package mma_pkg;

  // Store geometry
  localparam int MAX_DIM   = 8;
  localparam int DIM_LIMIT = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(DEPTH);

  // Field widths
  localparam int IDX_W      = 3;
  localparam int CNT_W      = 4;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;

  typedef enum logic [1:0] {
    MODE_LOAD_FIRST  = 2'd0,
    MODE_LOAD_SECOND = 2'd1,
    MODE_LOAD_TARGET = 2'd2,
    MODE_COMPUTE     = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT   = 3'd0,
    CFG_COL_COUNT   = 3'd1,
    CFG_INNER_COUNT = 3'd2,
    CFG_ACC_MODE    = 3'd3,
    CFG_ADD_SCALE   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SUM,
    ST_SCALE,
    ST_WRITE
  } state_t;

  function automatic logic [ADDR_W-1:0] mk_addr(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] c);
    return (int'(c) > DIM_LIMIT) ? CNT_W'(DIM_LIMIT) : c;
  endfunction

  // Round a Q32.32 product to Q16.16: add half an LSB, floor shift by 16.
  function automatic logic signed [ACC_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(32768);
    return t[PROD_W-1:16];
  endfunction

  function automatic logic signed [ACC_W-1:0] acc_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1])
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W:0] x);
    if (x > (ACC_W+1)'(signed'(32'h7fffffff)))
      return 32'sh7fffffff;
    if (x < (ACC_W+1)'(signed'(32'h80000000)))
      return 32'sh80000000;
    return x[DATA_W-1:0];
  endfunction

endpackage

FILE: rtl/mma_in_if.sv
`timescale 1ns / 1ps

interface mma_in_if;
  import mma_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink   (input valid, mode, row, col, value, output ready);
endinterface

FILE: rtl/mma_out_if.sv
`timescale 1ns / 1ps

interface mma_out_if;
  import mma_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [DATA_W-1:0] out_value;
  logic                     last;

  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, last, output ready);
endinterface

FILE: rtl/mma_ram.sv
`timescale 1ns / 1ps

module mma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/matrix_multiply_accumulate_unit.sv
`timescale 1ns / 1ps

// GEMM on Q16.16: target = A * B, or target + add_scale * (A * B) in accumulate
// mode. A, B and target live in three 64-entry RAMs. A load beat (mode 0/1/2)
// writes one element; loads may stream back to back while the block is idle. A
// compute beat walks the target column by column, row by row within a column,
// and per element issues one A/B read pair per cycle into a single 32x32
// multiplier, drains the MAC through the read data, product and accumulator
// registers, saturates in ST_SUM, scales in ST_SCALE (accumulate only) and
// writes back and emits in ST_WRITE once the output register is free. The
// element rate is set by that one multiplier and the single read port of each
// factor RAM. in_bus.ready stays low until the last element is handed to the
// output register. Results leave through a one-beat output register, so the
// next element is worked on while a result waits.
// The accumulator is 48 bits and saturates on every add; results saturate to
// 32 bits. Store contents are undefined until loaded.

module matrix_multiply_accumulate_unit
  import mma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mma_in_if.sink                in_bus,
  mma_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [CNT_W-1:0]         row_count_r, col_count_r, inner_count_r;
  logic                     acc_mode_r;
  logic signed [DATA_W-1:0] add_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= CNT_W'(8);
      col_count_r   <= CNT_W'(8);
      inner_count_r <= CNT_W'(8);
      acc_mode_r    <= 1'b0;
      add_scale_r   <= Q_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:   row_count_r   <= cfg_wdata[CNT_W-1:0];
        CFG_COL_COUNT:   col_count_r   <= cfg_wdata[CNT_W-1:0];
        CFG_INNER_COUNT: inner_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_ACC_MODE:    acc_mode_r    <= cfg_wdata[0];
        CFG_ADD_SCALE:   add_scale_r   <= signed'(cfg_wdata[DATA_W-1:0]);
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Counts above the store size act as the store size
  logic [CNT_W-1:0] rc, cc, ic;
  assign rc = clamp_cnt(row_count_r);
  assign cc = clamp_cnt(col_count_r);
  assign ic = clamp_cnt(inner_count_r);

  // Sequencer state
  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         r_r, c_r;       // current target element
  logic [CNT_W-1:0]         k_r;            // next inner index to issue
  logic                     rd_v_r;         // factor read data valid this cycle
  logic                     prd_v_r;        // product register valid this cycle
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DATA_W-1:0] res_r;
  logic signed [PROD_W-1:0] scl_r;

  // Output register
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r;

  // Control decode
  logic in_ready, issue, mac_done, wr_go, out_free;
  logic in_acc, is_compute, in_range, elem_last, run_ok;

  assign out_free   = !out_valid_r || out_bus.ready;
  assign in_acc     = in_bus.valid && in_ready;
  assign is_compute = (in_bus.mode == MODE_COMPUTE);
  assign in_range   = (int'(in_bus.row) < DIM_LIMIT) && (int'(in_bus.col) < DIM_LIMIT);
  assign run_ok     = (rc != '0) && (cc != '0);
  assign elem_last  = (({1'b0, r_r} + 1'b1) == rc) && (({1'b0, c_r} + 1'b1) == cc);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && is_compute && run_ok) state_nxt = ST_MAC;
      ST_MAC:   if (mac_done) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = acc_mode_r ? ST_SCALE : ST_WRITE;
      ST_SCALE: state_nxt = ST_WRITE;
      ST_WRITE: if (out_free) state_nxt = elem_last ? ST_IDLE : ST_MAC;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    issue    = (state_r == ST_MAC) && (k_r < ic);
    mac_done = (state_r == ST_MAC) && (k_r >= ic) && !rd_v_r && !prd_v_r;
    wr_go    = (state_r == ST_WRITE) && out_free;
  end

  // Memories
  logic                     a_we, b_we, t_we;
  logic [ADDR_W-1:0]        ld_addr, t_addr, t_wr_addr;
  logic [DATA_W-1:0]        t_wr_data;
  logic signed [DATA_W-1:0] a_rd, b_rd, t_rd;
  logic signed [DATA_W-1:0] final_val;
  logic signed [ACC_W-1:0]  scl_rnd;

  assign ld_addr   = mk_addr(in_bus.row, in_bus.col);
  assign t_addr    = mk_addr(r_r, c_r);
  assign a_we      = in_acc && in_range && (in_bus.mode == MODE_LOAD_FIRST);
  assign b_we      = in_acc && in_range && (in_bus.mode == MODE_LOAD_SECOND);
  assign t_we      = (in_acc && in_range && (in_bus.mode == MODE_LOAD_TARGET)) || wr_go;
  assign t_wr_addr = wr_go ? t_addr : ld_addr;
  assign t_wr_data = wr_go ? final_val : in_bus.value;

  mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
    .clk     (clk),
    .we      (a_we),
    .wr_addr (ld_addr),
    .wr_data (in_bus.value),
    .rd_addr (mk_addr(r_r, k_r[IDX_W-1:0])),
    .rd_data (a_rd)
  );

  mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
    .clk     (clk),
    .we      (b_we),
    .wr_addr (ld_addr),
    .wr_data (in_bus.value),
    .rd_addr (mk_addr(k_r[IDX_W-1:0], c_r)),
    .rd_data (b_rd)
  );

  // Old target entry: address holds for the whole element, so the read
  // data has settled long before write-back.
  mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_t (
    .clk     (clk),
    .we      (t_we),
    .wr_addr (t_wr_addr),
    .wr_data (t_wr_data),
    .rd_addr (t_addr),
    .rd_data (t_rd)
  );

  // Write-back value: plain saturated sum, or old + round(scaled sum)
  assign scl_rnd = round_q16(scl_r);

  always_comb begin
    if (acc_mode_r) begin
      final_val = sat32({{(ACC_W+1-DATA_W){t_rd[DATA_W-1]}}, t_rd}
                        + {scl_rnd[ACC_W-1], scl_rnd});
    end else begin
      final_val = res_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      prd_v_r     <= 1'b0;
      k_r         <= '0;
      r_r         <= '0;
      c_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      prd_v_r <= rd_v_r;
      if (issue) begin
        k_r <= k_r + 1'b1;
      end
      if (in_acc && is_compute) begin
        k_r <= '0;
        r_r <= '0;
        c_r <= '0;
      end
      if (wr_go) begin
        k_r <= '0;
        if (({1'b0, r_r} + 1'b1) == rc) begin
          r_r <= '0;
          c_r <= c_r + 1'b1;
        end else begin
          r_r <= r_r + 1'b1;
        end
      end
      if (wr_go) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prod_r <= a_rd * b_rd;
    end
    if ((in_acc && is_compute) || wr_go) begin
      acc_r <= '0;
    end else if (prd_v_r) begin
      acc_r <= acc_add(acc_r, round_q16(prod_r));
    end
    if (state_r == ST_SUM) begin
      res_r <= sat32({acc_r[ACC_W-1], acc_r});
    end
    if (state_r == ST_SCALE) begin
      scl_r <= res_r * add_scale_r;
    end
    if (wr_go) begin
      out_row_r   <= r_r;
      out_col_r   <= c_r;
      out_value_r <= final_val;
      out_last_r  <= elem_last;
    end
  end

  assign in_bus.ready      = in_ready;
  assign out_bus.valid     = out_valid_r;
  assign out_bus.out_row   = out_row_r;
  assign out_bus.out_col   = out_col_r;
  assign out_bus.out_value = out_value_r;
  assign out_bus.last      = out_last_r;

endmodule

FILE: rtl/mma_checker.sv
`timescale 1ns / 1ps

module mma_checker
  import mma_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_mode,
  input logic              out_valid,
  input logic              out_ready,
  input logic [IDX_W-1:0]  out_row,
  input logic [IDX_W-1:0]  out_col,
  input logic [DATA_W-1:0] out_value,
  input logic              out_last
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_row, out_col, out_value, out_last}))
    else $error("result beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode != MODE_COMPUTE) && !out_valid |=> !out_valid)
    else $error("result appeared after a load beat");

  // Mid-run result pending means the run is not over
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input accepted in the middle of a result run");

endmodule

bind matrix_multiply_accumulate_unit mma_checker u_mma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_mode   (in_bus.mode),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_row   (out_bus.out_row),
  .out_col   (out_bus.out_col),
  .out_value (out_bus.out_value),
  .out_last  (out_bus.last)
);

FILE: dv/tb_matrix_multiply_accumulate_unit.sv
`timescale 1ns / 1ps

module tb_matrix_multiply_accumulate_unit;
  import mma_pkg::*;

  // Settle time after the last result beat before a register write. It covers
  // a load, and a compute beat that produces no elements.
  localparam int SETTLE_CYCLES  = 24;
  // Long output hold-off used by the back-pressure test.
  localparam int HOLD_CYCLES    = 300;
  // Cycles with no beat on either channel before the run is declared hung.
  // The worst case is the hold-off above plus one element in flight.
  localparam int WATCHDOG_LIMIT = 3000;
  // Random beats per idling mix.
  localparam int PHASE_BEATS    = 60;

  localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -64'sh8000_0000_0000;
  localparam longint I32_HI = 64'sh7FFF_FFFF;
  localparam longint I32_LO = -64'sh8000_0000;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              last;
  } element_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mma_in_if  in_bus ();
  mma_out_if out_bus ();

  matrix_multiply_accumulate_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: three element stores, which entries have been
  // written, and the register values. Updated at every accepted beat and
  // every register write.
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] first_mat  [DEPTH];
  logic signed [DATA_W-1:0] second_mat [DEPTH];
  logic signed [DATA_W-1:0] target_mat [DEPTH];
  bit                       first_seen  [DEPTH];
  bit                       second_seen [DEPTH];
  bit                       target_seen [DEPTH];

  logic [CNT_W-1:0]         row_cnt   = 4'd8;
  logic [CNT_W-1:0]         col_cnt   = 4'd8;
  logic [CNT_W-1:0]         inner_cnt = 4'd8;
  logic                     acc_on    = 1'b0;
  logic signed [DATA_W-1:0] scale_q   = Q_ONE;

  // Elements the block owes us, oldest first.
  element_t pending_elements [$];

  int unsigned beats_sent;
  int unsigned computes_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_requests;
  int unsigned holds_served;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  // Counts above the store size behave as the store size.
  function automatic int unsigned eff_count(input logic [CNT_W-1:0] c);
    return (int'(c) > DIM_LIMIT) ? DIM_LIMIT : int'(c);
  endfunction

  // Q32.32 -> Q16.16, round half up (add half an LSB, floor).
  function automatic longint round_to_q16(input longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // One compute beat: walk the target column-major, queue every element and
  // write it back into the shadow target.
  task automatic compute_target_elements();
    int unsigned nr, nc, nk, r, c, k, t;
    longint      acc, sum, scaled;
    element_t    e;
    nr = eff_count(row_cnt);
    nc = eff_count(col_cnt);
    nk = eff_count(inner_cnt);
    for (c = 0; c < nc; c++) begin
      for (r = 0; r < nr; r++) begin
        acc = 0;
        for (k = 0; k < nk; k++) begin
          acc = clip(acc + round_to_q16(longint'(first_mat[r*MAX_DIM+k]) *
                                        longint'(second_mat[k*MAX_DIM+c])),
                     ACC_LO, ACC_HI);
        end
        sum = clip(acc, I32_LO, I32_HI);
        t = r * MAX_DIM + c;
        if (acc_on) begin
          scaled = round_to_q16(sum * longint'(scale_q));
          sum = clip(longint'(target_mat[t]) + scaled, I32_LO, I32_HI);
        end
        target_mat[t]  = DATA_W'(sum);
        target_seen[t] = 1'b1;
        e.row   = IDX_W'(r);
        e.col   = IDX_W'(c);
        e.value = DATA_W'(sum);
        e.last  = (c + 1 == nc) && (r + 1 == nr);
        pending_elements.push_back(e);
      end
    end
  endtask

  task automatic predict_beat(input mode_t m, input logic [IDX_W-1:0] r,
                              input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
    int unsigned a;
    a = int'(r) * MAX_DIM + int'(c);
    if (m == MODE_COMPUTE) begin
      compute_target_elements();
    end else if (int'(r) < DIM_LIMIT && int'(c) < DIM_LIMIT) begin
      case (m)
        MODE_LOAD_FIRST: begin
          first_mat[a]  = v;
          first_seen[a] = 1'b1;
        end
        MODE_LOAD_SECOND: begin
          second_mat[a]  = v;
          second_seen[a] = 1'b1;
        end
        default: begin
          target_mat[a]  = v;
          target_seen[a] = 1'b1;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 12) begin
      case ($urandom_range(3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (w < 50) return $urandom;
    // +/-8.0 keeps most sums inside 32 bits
    return DATA_W'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
  endfunction

  function automatic logic [DATA_W-1:0] pick_scale();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 10) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (w < 25) return Q_ONE;
    if (w < 70) return DATA_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    return $urandom;
  endfunction

  // Mostly small shapes; now and then empty, full, or above the store size.
  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 6)  return 4'd0;
    if (w < 13) return CNT_W'($urandom_range(9, 15));
    if (w < 20) return 4'd8;
    return CNT_W'($urandom_range(1, 4));
  endfunction

  // One beat on the input channel, with a random idle gap ahead of it.
  // valid is left high on return so the next beat can follow directly.
  task automatic send_beat(input mode_t m, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_bus.valid <= 1'b1;
    in_bus.mode  <= m;
    in_bus.row   <= r;
    in_bus.col   <= c;
    in_bus.value <= v;
    do @(posedge clk); while (!in_bus.ready);
    predict_beat(m, r, c, v);
    beats_sent++;
    if (m == MODE_COMPUTE) computes_sent++;
  endtask

  // Drop valid, wait for every owed element, then let the block go idle.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_ROW_COUNT:   row_cnt   = data[CNT_W-1:0];
      CFG_COL_COUNT:   col_cnt   = data[CNT_W-1:0];
      CFG_INNER_COUNT: inner_cnt = data[CNT_W-1:0];
      CFG_ACC_MODE:    acc_on    = data[0];
      CFG_ADD_SCALE:   scale_q   = data;
      default: ;
    endcase
  endtask

  // Writes all five registers; only call with the block idle.
  task automatic configure(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols,
                           input logic [CNT_W-1:0] inner, input logic acc,
                           input logic [CFG_DATA_W-1:0] scale);
    put_reg(CFG_ROW_COUNT,   CFG_DATA_W'(rows));
    put_reg(CFG_COL_COUNT,   CFG_DATA_W'(cols));
    put_reg(CFG_INNER_COUNT, CFG_DATA_W'(inner));
    put_reg(CFG_ACC_MODE,    CFG_DATA_W'(acc));
    put_reg(CFG_ADD_SCALE,   scale);
    cfg_we <= 1'b0;
  endtask

  // Load every entry the next compute will read that has never been loaded.
  task automatic fill_unwritten();
    int unsigned nr, nc, nk, r, c, k;
    nr = eff_count(row_cnt);
    nc = eff_count(col_cnt);
    nk = eff_count(inner_cnt);
    if (nr == 0 || nc == 0) return;
    for (r = 0; r < nr; r++)
      for (k = 0; k < nk; k++)
        if (!first_seen[r*MAX_DIM+k])
          send_beat(MODE_LOAD_FIRST, IDX_W'(r), IDX_W'(k), pick_value());
    for (k = 0; k < nk; k++)
      for (c = 0; c < nc; c++)
        if (!second_seen[k*MAX_DIM+c])
          send_beat(MODE_LOAD_SECOND, IDX_W'(k), IDX_W'(c), pick_value());
    if (acc_on)
      for (r = 0; r < nr; r++)
        for (c = 0; c < nc; c++)
          if (!target_seen[r*MAX_DIM+c])
            send_beat(MODE_LOAD_TARGET, IDX_W'(r), IDX_W'(c), pick_value());
  endtask

  // Fresh factors over the active shape; in accumulate mode some target too.
  task automatic reload_active();
    int unsigned nr, nc, nk, r, c, k;
    nr = eff_count(row_cnt);
    nc = eff_count(col_cnt);
    nk = eff_count(inner_cnt);
    for (r = 0; r < nr; r++)
      for (k = 0; k < nk; k++)
        send_beat(MODE_LOAD_FIRST, IDX_W'(r), IDX_W'(k), pick_value());
    for (k = 0; k < nk; k++)
      for (c = 0; c < nc; c++)
        send_beat(MODE_LOAD_SECOND, IDX_W'(k), IDX_W'(c), pick_value());
    if (acc_on)
      for (r = 0; r < nr; r++)
        for (c = 0; c < nc; c++)
          if ($urandom_range(1))
            send_beat(MODE_LOAD_TARGET, IDX_W'(r), IDX_W'(c), pick_value());
  endtask

  task automatic send_compute();
    send_beat(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // 1x1 target, inner count 15 (behaves as 8). Three max*max terms overflow
  // the 48-bit accumulator, two min*max terms pull it back down, so a wide
  // or unsaturated accumulator gives a different answer. Also a term of
  // exactly 0.5 (-1 LSB * -32768.0) and a plain -1.5.
  task automatic test_saturating_dot_product();
    int unsigned k;
    configure(4'd1, 4'd1, 4'd15, 1'b0, Q_ONE);
    for (k = 0; k < 3; k++) begin
      send_beat(MODE_LOAD_FIRST,  3'd0, IDX_W'(k), 32'h7FFF_FFFF);
      send_beat(MODE_LOAD_SECOND, IDX_W'(k), 3'd0, 32'h7FFF_FFFF);
    end
    for (k = 3; k < 5; k++) begin
      send_beat(MODE_LOAD_FIRST,  3'd0, IDX_W'(k), 32'h8000_0000);
      send_beat(MODE_LOAD_SECOND, IDX_W'(k), 3'd0, 32'h7FFF_FFFF);
    end
    send_beat(MODE_LOAD_FIRST,  3'd0, 3'd5, 32'hFFFF_FFFF);
    send_beat(MODE_LOAD_SECOND, 3'd5, 3'd0, 32'h8000_0000);
    send_beat(MODE_LOAD_FIRST,  3'd0, 3'd6, 32'h0000_0000);
    send_beat(MODE_LOAD_SECOND, 3'd6, 3'd0, $urandom);
    send_beat(MODE_LOAD_FIRST,  3'd0, 3'd7, 32'h0001_8000);
    send_beat(MODE_LOAD_SECOND, 3'd7, 3'd0, 32'hFFFF_0000);
    send_compute();
  endtask

  // Accumulate onto a full-scale target with the most negative scale.
  task automatic test_scaled_accumulate_extremes();
    settle();
    configure(4'd1, 4'd1, 4'd8, 1'b1, 32'h8000_0000);
    send_beat(MODE_LOAD_TARGET, 3'd7, 3'd7, 32'h8000_0000);
    send_beat(MODE_LOAD_TARGET, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_compute();
  endtask

  // Zero rows, then zero columns: compute beats that must produce nothing.
  task automatic test_empty_compute();
    settle();
    configure(4'd0, 4'd8, 4'd8, 1'b0, Q_ONE);
    send_compute();
    settle();
    configure(4'd1, 4'd0, 4'd0, 1'b1, 32'h7FFF_FFFF);
    send_compute();
  endtask

  // Hold the output off for a long stretch while a 64-element compute runs
  // and loads keep coming; the block must stall its input and lose nothing.
  task automatic test_output_hold_off();
    int unsigned n;
    settle();
    configure(4'd8, 4'd8, 4'd1, 1'b0, Q_ONE);
    fill_unwritten();
    hold_requests++;
    send_compute();
    for (n = 0; n < 6; n++)
      send_beat(mode_t'($urandom_range(2)), IDX_W'($urandom), IDX_W'($urandom), pick_value());
    send_compute();
  endtask

  // Random shapes and registers; each round reloads factors, mixes in stray
  // loads or just repeats the compute, and always keeps the read set loaded.
  task automatic test_random_jobs(input int unsigned sender_idle, input int unsigned rx_stall);
    int unsigned start, jobs, shape, n;
    send_idle_pct  = sender_idle;
    recv_stall_pct = rx_stall;
    start = beats_sent;
    while (beats_sent - start < PHASE_BEATS) begin
      settle();
      configure(pick_count(), pick_count(), pick_count(), 1'($urandom_range(1)),
                pick_scale());
      jobs = $urandom_range(1, 3);
      repeat (jobs) begin
        shape = $urandom_range(99);
        if (shape < 70) begin
          reload_active();
        end else if (shape < 90) begin
          n = $urandom_range(1, 8);
          repeat (n)
            send_beat(mode_t'($urandom_range(2)), IDX_W'($urandom), IDX_W'($urandom),
                      pick_value());
        end
        fill_unwritten();
        send_compute();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus the long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served  <= holds_served + 1;
      hold_left     <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: every accepted beat against the oldest owed element.
  always @(posedge clk) begin
    element_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_checked++;
      if (pending_elements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result row %0d col %0d value %h last %b", $realtime,
                   out_bus.out_row, out_bus.out_col, out_bus.out_value, out_bus.last);
      end else begin
        want = pending_elements.pop_front();
        if (out_bus.out_row !== want.row || out_bus.out_col !== want.col ||
            out_bus.out_value !== want.value || out_bus.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected row %0d col %0d value %h last %b, got row %0d col %0d value %h last %b",
                     $realtime, want.row, want.col, want.value, want.last,
                     out_bus.out_row, out_bus.out_col, out_bus.out_value, out_bus.last);
        end
      end
    end
  end

  // Watchdog: too long without a beat on either channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a beat, %0d elements still owed",
               quiet_cycles, pending_elements.size());
      $display("** matrix_multiply_accumulate_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_ROW_COUNT;
    cfg_wdata     = '0;
    in_bus.valid  = 1'b0;
    in_bus.mode   = MODE_LOAD_FIRST;
    in_bus.row    = '0;
    in_bus.col    = '0;
    in_bus.value  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, no idling
    test_saturating_dot_product();
    test_scaled_accumulate_extremes();
    test_empty_compute();
    test_output_hold_off();

    // random, one pass per idling mix
    test_random_jobs(0, 0);
    test_random_jobs(58, 0);
    test_random_jobs(0, 58);
    test_random_jobs(18, 18);

    settle();
    $display("Sent %0d input beats (%0d compute), checked %0d result beats, %0d mismatches.",
             beats_sent, computes_sent, results_checked, mismatches);
    $display("Shapes from empty to over-size, both target modes, scale extremes, four idle mixes.");
    if (mismatches == 0 && pending_elements.size() == 0) begin
      $display("** matrix_multiply_accumulate_unit: PASSED **");
    end else begin
      $display("** matrix_multiply_accumulate_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: matrix_multiply_accumulate_unit.f
rtl/mma_pkg.sv
rtl/mma_in_if.sv
rtl/mma_out_if.sv
rtl/mma_ram.sv
rtl/matrix_multiply_accumulate_unit.sv
rtl/mma_checker.sv
dv/tb_matrix_multiply_accumulate_unit.sv
